// ===== src/min_tracking_deque_assert.svh =====
// ----------------------------------------------------------------------------
// min_tracking_deque_assert.svh
// Assertion macros for the min tracking deque. They expand to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_DEQUE_ASSERT_SVH
`define MIN_TRACKING_DEQUE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define MTD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("min_tracking_deque assertion failed");
// Checked on every rising edge, reset included.
`define MTD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("min_tracking_deque assertion failed");
`else
`define MTD_ASSERT(lbl, prop)
`define MTD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== src/mtd_pkg.sv =====
// ----------------------------------------------------------------------------
// mtd_pkg
// Shared constants, operation codes and request, response and cell control
// types of the min tracking deque.
// ----------------------------------------------------------------------------
package mtd_pkg;

  // Number of cells in the chain.
  localparam int DEPTH = 64;
  // Width of a cell index and of the occupancy count (which can reach DEPTH).
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Operation codes.
  localparam logic [1:0] MODE_PUSH_BACK  = 2'd0;
  localparam logic [1:0] MODE_PUSH_FRONT = 2'd1;
  localparam logic [1:0] MODE_POP_BACK   = 2'd2;
  localparam logic [1:0] MODE_POP_FRONT  = 2'd3;

  // Largest signed word, used as the neutral element of the minimum.
  localparam logic signed [31:0] VAL_MAX   = 32'sh7FFF_FFFF;
  // Reported minimum of an empty deque.
  localparam logic signed [31:0] EMPTY_MIN = -32'sd1;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] minimum;
    logic               empty_res;
    logic               overflow;
  } rsp_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic load;        // push back: the cell at the back position takes the value
    logic shift_r;     // push front: every cell takes its left neighbour
    logic shift_l;     // pop front: every cell takes its right neighbour
    logic sweep;       // minimum sweep in progress
  } cell_ctrl_t;

endpackage

// ===== src/mtd_cell.sv =====
// ----------------------------------------------------------------------------
// mtd_cell
// One cell of the deque chain. It holds one stored value and one running
// minimum, and exchanges both with its neighbours.
// ----------------------------------------------------------------------------
module mtd_cell import mtd_pkg::*; (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               occupied,
  input  logic               wr_here,
  input  logic signed [31:0] push_val,
  input  logic signed [31:0] left_val,
  input  logic signed [31:0] right_val,
  input  logic signed [31:0] min_in,
  output logic signed [31:0] val,
  output logic signed [31:0] min_out
);

  logic signed [31:0] key;

  // An empty cell takes no part in the minimum.
  assign key = occupied ? val : VAL_MAX;

  // Stored value: written on push back, moved along on push front and pop front.
  // The three controls never coincide, and with none of them the value holds.
  always_ff @(posedge clk) begin
    if (ctrl.load && wr_here) begin
      val <= push_val;
    end else if (ctrl.shift_r) begin
      val <= left_val;
    end else if (ctrl.shift_l) begin
      val <= right_val;
    end
  end

  // Running minimum flows from the back of the chain towards the front.
  always_ff @(posedge clk) begin
    if (ctrl.sweep) begin
      min_out <= (key < min_in) ? key : min_in;
    end
  end

endmodule

// ===== src/min_tracking_deque.sv =====
// ----------------------------------------------------------------------------
// min_tracking_deque
// Bounded deque of signed words in a chain of cells that reports the minimum
// of the held values after every push or pop.
// ----------------------------------------------------------------------------
// Sequencing: a taken request is followed by the minimum sweep, which walks the running
// minimum through all DEPTH cells, one cell per cycle, and then by the response. No new
// request is taken until the response has been taken.
// Reset: synchronous, active high; empties the deque and returns to idle.
// Cell contents are not cleared: only occupied cells enter the minimum.
// ----------------------------------------------------------------------------
`include "min_tracking_deque_assert.svh"

module min_tracking_deque import mtd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_RESP  = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] sweep_cnt;
  logic             overflow;

  logic             accept;
  logic             full;
  logic             is_push;
  cell_ctrl_t       ctrl;
  logic             sweep_first;

  logic signed [31:0] cell_val [DEPTH];
  logic signed [31:0] cell_min [DEPTH];

  // Request handshake.
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign full      = (count == CNT_W'(DEPTH));
  assign is_push   = (req.mode == MODE_PUSH_BACK) || (req.mode == MODE_PUSH_FRONT);

  // Cell control for the operation and the sweep.
  always_comb begin
    ctrl.load    = accept && (req.mode == MODE_PUSH_BACK) && !full;
    ctrl.shift_r = accept && (req.mode == MODE_PUSH_FRONT) && !full;
    ctrl.shift_l = accept && (req.mode == MODE_POP_FRONT) && (count != '0);
    ctrl.sweep   = (state == ST_SWEEP);
  end

  assign sweep_first = ctrl.sweep && (sweep_cnt == '0);

  // Occupancy update.
  always_comb begin
    count_next = count;
    if (accept) begin
      if (is_push) begin
        if (!full) begin
          count_next = count + CNT_W'(1);
        end
      end else if (count != '0) begin
        count_next = count - CNT_W'(1);
      end
    end
  end

  // Sequencer: operation, sweep over the chain, response.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sweep_cnt == IDX_W'(DEPTH - 1)) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      sweep_cnt <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (ctrl.sweep) begin
        sweep_cnt <= sweep_cnt + IDX_W'(1);
      end else begin
        sweep_cnt <= '0;
      end
    end
  end

  // The dropped-push flag is kept for the response.
  always_ff @(posedge clk) begin
    if (accept) begin
      overflow <= is_push && full;
    end
  end

  // The chain of cells; the front of the deque is cell 0.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               occupied;
    logic               wr_here;
    logic signed [31:0] left_val;
    logic signed [31:0] right_val;
    logic signed [31:0] min_in;

    assign occupied = (CNT_W'(i) < count);
    assign wr_here  = (CNT_W'(i) == count);

    if (i == 0) begin : g_front
      assign left_val = req.value;
    end else begin : g_inner_l
      assign left_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign right_val = VAL_MAX;
      assign min_in    = VAL_MAX;
    end else begin : g_inner_r
      assign right_val = cell_val[i+1];
      assign min_in    = sweep_first ? VAL_MAX : cell_min[i+1];
    end

    mtd_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occupied),
      .wr_here   (wr_here),
      .push_val  (req.value),
      .left_val  (left_val),
      .right_val (right_val),
      .min_in    (min_in),
      .val       (cell_val[i]),
      .min_out   (cell_min[i])
    );
  end

  // Response; the cells hold still while it waits.
  assign rsp_valid     = (state == ST_RESP);
  assign rsp.minimum   = (count == '0) ? EMPTY_MIN : cell_min[0];
  assign rsp.empty_res = (count == '0);
  assign rsp.overflow  = overflow;

  // A taken request always starts a sweep.
  `MTD_ASSERT(a_accept_sweeps, accept |=> (state == ST_SWEEP))
  // A response is offered only straight after a complete sweep or while stalled.
  `MTD_ASSERT(a_rsp_after_sweep, $rose(rsp_valid) |-> ($past(state) == ST_SWEEP))
  // A dropped push leaves the occupancy unchanged at full.
  `MTD_ASSERT(a_overflow_full, (rsp_valid && rsp.overflow) |-> (count == CNT_W'(DEPTH)))
  // The occupancy never exceeds the chain length; before the first reset it is unknown.
  `MTD_ASSERT_ALWAYS(a_count_bound, rst || (count <= CNT_W'(DEPTH)))

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the min tracking deque against a queue-based model of its contents.
// A short table of directed requests covers the empty, single-value and full
// cases, then random push and pop requests with a drifting push bias fill and
// drain the deque many times. Both handshake sides idle in random bursts.
// ----------------------------------------------------------------------------
module testbench import mtd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1110;
  localparam int QUIET_TAIL      = 150;
  localparam int PAUSE_AT        = 600;

  // One row of the directed table; the expected response is typed in only
  // where it is obvious, otherwise the model supplies it.
  typedef struct {
    logic [1:0]         mode;
    logic signed [31:0] value;
    int                 reps;
    bit                 typed;
    rsp_t               want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Model state and the responses still owed by the block.
  logic signed [31:0] held_values[$];
  rsp_t               expected_min[$];
  step_row_t          directed_rows[$];
  int                 mismatch_count = 0;
  bit                 quiet = 1'b0;

  min_tracking_deque u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one request to the model and returns the response it implies.
  function automatic rsp_t predict_min(input req_t r);
    rsp_t               res;
    logic signed [31:0] lowest;
    res = '0;
    case (r.mode)
      MODE_PUSH_BACK: begin
        if (held_values.size() >= DEPTH) res.overflow = 1'b1;
        else held_values.insert(held_values.size(), r.value);
      end
      MODE_PUSH_FRONT: begin
        if (held_values.size() >= DEPTH) res.overflow = 1'b1;
        else held_values.insert(0, r.value);
      end
      MODE_POP_BACK: begin
        if (held_values.size() > 0) held_values.delete(held_values.size() - 1);
      end
      MODE_POP_FRONT: begin
        if (held_values.size() > 0) held_values.delete(0);
      end
    endcase
    if (held_values.size() == 0) begin
      res.minimum   = EMPTY_MIN;
      res.empty_res = 1'b1;
    end else begin
      lowest = held_values[0];
      foreach (held_values[i]) begin
        if (held_values[i] < lowest) lowest = held_values[i];
      end
      res.minimum = lowest;
    end
    return res;
  endfunction

  task automatic add_row(input logic [1:0] m, input logic signed [31:0] v, input int reps,
                         input bit typed, input logic signed [31:0] w_min,
                         input logic w_empty, input logic w_ovf);
    step_row_t row;
    row.mode  = m;
    row.value = v;
    row.reps  = reps;
    row.typed = typed;
    row.want  = '{minimum: w_min, empty_res: w_empty, overflow: w_ovf};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Offers one request, holds it until taken, then records the expected response.
  task automatic send_request(input req_t r, input bit typed, input rsp_t want);
    rsp_t predicted;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    predicted = predict_min(r);
    expected_min.insert(expected_min.size(), typed ? want : predicted);
  endtask

  task automatic report_mismatch(input string what, input rsp_t want, input rsp_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"%0t: %s: expected min %0d empty %0b overflow %0b, ",
                "got min %0d empty %0b overflow %0b"},
               $realtime, what, want.minimum, want.empty_res, want.overflow,
               got.minimum, got.empty_res, got.overflow);
  endtask

  // Response checker: every accepted response is matched against the oldest one owed.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_min.size() == 0) begin
        report_mismatch("response with none expected", '0, rsp);
      end else begin
        want = expected_min[0];
        expected_min.delete(0);
        if (rsp.minimum !== want.minimum || rsp.empty_res !== want.empty_res ||
            rsp.overflow !== want.overflow)
          report_mismatch("response mismatch", want, rsp);
      end
    end
  end

  // Response side stalls in random bursts until the quiet tail of the run.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) rsp_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_stall  <= 1'b1;
        stall_left = $urandom_range(1, 12);
      end
    end
  end

  // Request side: reset, directed table, then biased random traffic.
  initial begin
    int                 push_bias[4];
    int                 pct;
    req_t               r;
    logic signed [31:0] v;
    push_bias = '{90, 55, 10, 45};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Empty deque, single extreme values, duplicates, then fill, overflow and drain.
    add_row(MODE_POP_BACK,   32'sd0,            1, 1, EMPTY_MIN,         1'b1, 1'b0);
    add_row(MODE_POP_FRONT,  32'sh0000_1234,    1, 1, EMPTY_MIN,         1'b1, 1'b0);
    add_row(MODE_PUSH_BACK,  VAL_MAX,           1, 1, VAL_MAX,           1'b0, 1'b0);
    add_row(MODE_PUSH_FRONT, 32'sh8000_0000,    1, 1, 32'sh8000_0000,    1'b0, 1'b0);
    add_row(MODE_POP_FRONT,  32'sd0,            1, 1, VAL_MAX,           1'b0, 1'b0);
    add_row(MODE_POP_BACK,   32'sd0,            1, 1, EMPTY_MIN,         1'b1, 1'b0);
    add_row(MODE_PUSH_BACK,  -32'sd1,           1, 1, -32'sd1,           1'b0, 1'b0);
    add_row(MODE_PUSH_FRONT, 32'sd0,            1, 0, '0,                1'b0, 1'b0);
    add_row(MODE_PUSH_BACK,  32'sh5555_5555,    1, 0, '0,                1'b0, 1'b0);
    add_row(MODE_PUSH_FRONT, 32'shAAAA_AAAA,    1, 0, '0,                1'b0, 1'b0);
    add_row(MODE_POP_BACK,   32'sd0,            1, 0, '0,                1'b0, 1'b0);
    add_row(MODE_PUSH_BACK,  32'sd7,     DEPTH - 3, 0, '0,                1'b0, 1'b0);
    add_row(MODE_PUSH_BACK,  32'sh8000_0000,    1, 1, 32'shAAAA_AAAA,    1'b0, 1'b1);
    add_row(MODE_PUSH_FRONT, 32'sh8000_0000,    1, 1, 32'shAAAA_AAAA,    1'b0, 1'b1);
    add_row(MODE_POP_FRONT,  32'sd0,        DEPTH, 0, '0,                1'b0, 1'b0);
    add_row(MODE_POP_FRONT,  32'sd0,            1, 1, EMPTY_MIN,         1'b1, 1'b0);

    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        r.mode  = directed_rows[i].mode;
        r.value = directed_rows[i].value;
        send_request(r, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random traffic; the push bias drifts so the deque repeatedly fills and empties.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      quiet = (n >= RANDOM_REQUESTS - QUIET_TAIL);
      if (n == PAUSE_AT) begin
        req_valid <= 1'b0;
        while (expected_min.size() != 0) @(posedge clk);
      end
      pct = push_bias[(n / 120) % 4];
      if ($urandom_range(0, 99) < pct)
        r.mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
      else
        r.mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
      case ($urandom_range(0, 3))
        0, 1: v = $urandom;
        2: v = $signed($urandom_range(0, 8)) - 32'sd4;
        default: begin
          case ($urandom_range(0, 3))
            0: v = VAL_MAX;
            1: v = 32'sh8000_0000;
            2: v = EMPTY_MIN;
            default: v = 32'sd0;
          endcase
        end
      endcase
      r.value = v;
      send_request(r, 1'b0, '0);
    end

    // Drain what is owed, allow the block's latency for any stray response, then judge.
    req_valid <= 1'b0;
    while (expected_min.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog for a block that stops responding.
  initial begin
    #4_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
